>>> sv/ipd_pkg.sv
`default_nettype none

package ipd_pkg;

  // default depth of the length digit field
  localparam int MaxLengthDigits = 14;

  localparam int ByteW  = 8;
  localparam int CountW = 32;

  // header characters
  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChI     = 8'h49;
  localparam logic [ByteW-1:0] ChP     = 8'h50;
  localparam logic [ByteW-1:0] ChD     = 8'h44;
  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  // header match phase
  typedef enum logic [2:0] {
    PH_SEEK_PLUS  = 3'd0,
    PH_SEEK_I     = 3'd1,
    PH_SEEK_P     = 3'd2,
    PH_SEEK_D     = 3'd3,
    PH_SEEK_COMMA = 3'd4,
    PH_DIGITS     = 3'd5
  } phase_t;

  // control from the datapath to the header parser
  typedef struct packed {
    logic step;   // parse this byte
    logic clear;  // page start: clear parser before this byte
  } hdr_ctl_t;

  // parser result for the current byte
  typedef struct packed {
    logic              load;  // ':' closed a header
    logic [CountW-1:0] len;   // payload length of that header
  } hdr_res_t;

endpackage

`default_nettype wire

>>> sv/ipd_if.sv
`default_nettype none

// received byte channel
interface ipd_in_if;
  logic                      valid;
  logic                      ready;
  logic [ipd_pkg::ByteW-1:0] rx_byte;
  logic                      page_start;
  logic                      file_start;

  modport source (output valid, rx_byte, page_start, file_start, input ready);
  modport sink   (input valid, rx_byte, page_start, file_start, output ready);
endinterface

// result channel
interface ipd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       payload_valid;
  logic [ipd_pkg::ByteW-1:0]  payload_byte;
  logic                       file_complete;
  logic [ipd_pkg::CountW-1:0] accepted_count;

  modport source (output valid, payload_valid, payload_byte, file_complete, accepted_count,
                  input ready);
  modport sink   (input valid, payload_valid, payload_byte, file_complete, accepted_count,
                  output ready);
endinterface

`default_nettype wire

>>> sv/ipd_hdr_parser.sv
`default_nettype none

module ipd_hdr_parser #(
  parameter int MAX_LENGTH_DIGITS = ipd_pkg::MaxLengthDigits
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ipd_pkg::hdr_ctl_t         ctl,
  input  wire logic [ipd_pkg::ByteW-1:0] rx_byte,
  output ipd_pkg::hdr_res_t              res
);

  localparam int DigW = $clog2(MAX_LENGTH_DIGITS + 1);
  localparam int LenW = ipd_pkg::CountW;

  ipd_pkg::phase_t phase_r, phase_nxt, phase_eff;
  logic [DigW-1:0] dig_cnt_r, dig_cnt_nxt, dig_cnt_eff;
  logic [LenW-1:0] len_r, len_nxt, len_eff;

  logic            is_digit;
  logic [3:0]      digit_val;
  logic [LenW+3:0] len_x10;
  logic [LenW-1:0] len_sat;

  // page start clears the parser before this byte
  assign phase_eff   = ctl.clear ? ipd_pkg::PH_SEEK_PLUS : phase_r;
  assign dig_cnt_eff = ctl.clear ? '0 : dig_cnt_r;
  assign len_eff     = ctl.clear ? '0 : len_r;

  // len * 10 + digit, saturating at all ones
  assign is_digit  = (rx_byte >= ipd_pkg::ChZero) && (rx_byte <= ipd_pkg::ChNine);
  assign digit_val = 4'(rx_byte - ipd_pkg::ChZero);
  assign len_x10   = ({4'b0, len_eff} << 3) + ({4'b0, len_eff} << 1)
                   + {{LenW{1'b0}}, digit_val};
  assign len_sat   = (len_x10[LenW+3:LenW] != 4'b0) ? '1 : len_x10[LenW-1:0];

  // header match sequence
  always_comb begin
    phase_nxt   = phase_eff;
    dig_cnt_nxt = dig_cnt_eff;
    len_nxt     = len_eff;
    res.load    = 1'b0;
    res.len     = len_eff;
    if (ctl.step) begin
      case (phase_eff)
        ipd_pkg::PH_SEEK_PLUS: begin
          if (rx_byte == ipd_pkg::ChPlus) phase_nxt = ipd_pkg::PH_SEEK_I;
        end
        ipd_pkg::PH_SEEK_I: begin
          phase_nxt = (rx_byte == ipd_pkg::ChI) ? ipd_pkg::PH_SEEK_P : ipd_pkg::PH_SEEK_PLUS;
        end
        ipd_pkg::PH_SEEK_P: begin
          phase_nxt = (rx_byte == ipd_pkg::ChP) ? ipd_pkg::PH_SEEK_D : ipd_pkg::PH_SEEK_PLUS;
        end
        ipd_pkg::PH_SEEK_D: begin
          phase_nxt = (rx_byte == ipd_pkg::ChD) ? ipd_pkg::PH_SEEK_COMMA
                                                : ipd_pkg::PH_SEEK_PLUS;
        end
        ipd_pkg::PH_SEEK_COMMA: begin
          if (rx_byte == ipd_pkg::ChComma) begin
            phase_nxt   = ipd_pkg::PH_DIGITS;
            dig_cnt_nxt = '0;
            len_nxt     = '0;
          end else begin
            phase_nxt = ipd_pkg::PH_SEEK_PLUS;
          end
        end
        ipd_pkg::PH_DIGITS: begin
          if (rx_byte == ipd_pkg::ChColon) begin
            res.load  = 1'b1;
            phase_nxt = ipd_pkg::PH_SEEK_PLUS;
          end else if (is_digit && (dig_cnt_eff < DigW'(MAX_LENGTH_DIGITS))) begin
            len_nxt     = len_sat;
            dig_cnt_nxt = dig_cnt_eff + 1'b1;
          end else begin
            phase_nxt = ipd_pkg::PH_SEEK_PLUS;
          end
        end
        default: begin
          phase_nxt = ipd_pkg::PH_SEEK_PLUS;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ipd_pkg::PH_SEEK_PLUS;
      dig_cnt_r <= '0;
      len_r     <= '0;
    end else if (ctl.step || ctl.clear) begin
      phase_r   <= phase_nxt;
      dig_cnt_r <= dig_cnt_nxt;
      len_r     <= len_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/ipd_payload_deframer.sv
// Payload deframer for a modem byte stream.
// in_ch carries one received byte per beat with page_start and file_start
// flags; out_ch returns exactly one result beat per input beat, in order:
// payload_valid/payload_byte for bytes passed as file payload, plus
// file_complete and accepted_count after that byte.
// Headers of the form +IPD,<len>: are stripped; the length then counts down
// over the following bytes. Bytes pass only while accepted_count is below
// expected_size, written through cfg_wr_en/cfg_wr_data; the user must write
// it only while idle; the block itself does not enforce this. A beat goes
// through the input register, then the result register, to out_ch. One
// beat per cycle while out_ch is ready, set by the state update between
// the two registers. A stalled out_ch holds its result; the input register
// still takes one more beat, then in_ch.ready drops until out_ch drains.
// Reset (rst_n low at a clock edge) empties both registers, returns the
// header parser to searching and clears expected_size, the countdown, the
// accepted count and the completion flag.
`default_nettype none

module ipd_payload_deframer #(
  parameter int MAX_LENGTH_DIGITS = ipd_pkg::MaxLengthDigits
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ipd_pkg::CountW-1:0] cfg_wr_data,
  ipd_in_if.sink                          in_ch,
  ipd_out_if.source                       out_ch
);

  localparam int CntW = ipd_pkg::CountW;
  localparam int BW   = ipd_pkg::ByteW;

  logic [CntW-1:0] exp_size_r;

  // input register
  logic          a_valid_r;
  logic [BW-1:0] a_byte_r;
  logic          a_page_r;
  logic          a_file_r;

  // result register
  logic            o_valid_r;
  logic            o_pvalid_r, o_pvalid_nxt;
  logic [BW-1:0]   o_pbyte_r, o_pbyte_nxt;
  logic            o_done_r;
  logic [CntW-1:0] o_count_r;

  // block state
  logic [CntW-1:0] rem_r, rem_nxt, rem_eff;
  logic [CntW-1:0] acc_r, acc_nxt, acc_eff;
  logic            done_r, done_nxt, done_eff;

  logic advance, in_fire, step;

  ipd_pkg::hdr_ctl_t hdr_ctl;
  ipd_pkg::hdr_res_t hdr_res;

  assign advance     = !o_valid_r || out_ch.ready;
  assign in_ch.ready = !a_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign step        = a_valid_r && advance;

  // size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_size_r <= '0;
    end else if (cfg_wr_en) begin
      exp_size_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (advance) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_byte_r <= in_ch.rx_byte;
      a_page_r <= in_ch.page_start;
      a_file_r <= in_ch.file_start;
    end
  end

  // flags apply before the byte
  assign acc_eff  = a_file_r ? '0 : acc_r;
  assign done_eff = a_file_r ? 1'b0 : done_r;
  assign rem_eff  = a_page_r ? '0 : rem_r;

  assign hdr_ctl.step  = step && !done_eff && (rem_eff == '0);
  assign hdr_ctl.clear = step && a_page_r;

  ipd_hdr_parser #(
    .MAX_LENGTH_DIGITS(MAX_LENGTH_DIGITS)
  ) u_hdr (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (hdr_ctl),
    .rx_byte(a_byte_r),
    .res    (hdr_res)
  );

  // countdown, accepted count and completion
  always_comb begin
    rem_nxt      = rem_eff;
    acc_nxt      = acc_eff;
    done_nxt     = done_eff;
    o_pvalid_nxt = 1'b0;
    o_pbyte_nxt  = '0;
    if (!done_eff) begin
      if (rem_eff == '0) begin
        if (hdr_res.load) rem_nxt = hdr_res.len;
      end else begin
        rem_nxt = rem_eff - 1'b1;
        if (acc_eff < exp_size_r) begin
          acc_nxt      = acc_eff + 1'b1;
          o_pvalid_nxt = 1'b1;
          o_pbyte_nxt  = a_byte_r;
        end
      end
      if (acc_nxt >= exp_size_r) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      acc_r  <= '0;
      done_r <= 1'b0;
    end else if (step) begin
      rem_r  <= rem_nxt;
      acc_r  <= acc_nxt;
      done_r <= done_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (advance) begin
      o_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_pvalid_r <= o_pvalid_nxt;
      o_pbyte_r  <= o_pbyte_nxt;
      o_done_r   <= done_nxt;
      o_count_r  <= acc_nxt;
    end
  end

  assign out_ch.valid          = o_valid_r;
  assign out_ch.payload_valid  = o_pvalid_r;
  assign out_ch.payload_byte   = o_pbyte_r;
  assign out_ch.file_complete  = o_done_r;
  assign out_ch.accepted_count = o_count_r;

  // a finished file holds its count until a new file starts
  a_done_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    step && done_r && !a_file_r |=> acc_r == $past(acc_r))
    else $error("accepted count moved after completion");

  // a running countdown steps by one per beat
  a_countdown_step: assert property (@(posedge clk) disable iff (!rst_n)
    step && !a_page_r && !done_eff && (rem_r != '0) |=> rem_r == $past(rem_r) - 1'b1)
    else $error("payload countdown skipped");

  // a passed byte always counts toward the file
  a_payload_counted: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && o_pvalid_r |-> o_count_r != '0)
    else $error("payload beat with zero accepted count");

  // input stalls only when both registers are full
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> a_valid_r && o_valid_r && !out_ch.ready)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
